// ===== sv/xcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

   // frame layout
   localparam int unsigned POS_WIDTH    = 9;
   localparam int unsigned HEADER_BYTES = 4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_VALUE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD = 1'd1;

   // configuration reset values
   localparam logic [7:0] START_VALUE_RESET = 8'd170;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

   // verdict codes
   localparam logic [2:0] ERR_OK     = 3'd0;
   localparam logic [2:0] ERR_SHORT  = 3'd1;
   localparam logic [2:0] ERR_START  = 3'd2;
   localparam logic [2:0] ERR_LONG   = 3'd3;
   localparam logic [2:0] ERR_LENGTH = 3'd4;
   localparam logic [2:0] ERR_CHECK  = 3'd5;

   // one result of the checker
   typedef struct packed {
      logic       is_verdict;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [2:0] error_code;
      logic [7:0] message_id;
      logic [7:0] command;
      logic [7:0] payload_length;
   } result_type;

   // one received byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } rx_byte_type;

endpackage : xcfp_pkg
`default_nettype wire

// ===== sv/xcfp_frame_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfp_frame_check
// Frame state (position, running XOR, header bytes) and the single-pass
// logic that turns one byte into a payload result, a verdict or nothing.
// ----------------------------------------------------------------------------
module xcfp_frame_check (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire xcfp_pkg::rx_byte_type rx_byte,
   input  wire logic [7:0]           start_value,
   input  wire logic [7:0]           max_payload,
   output      logic                 has_result,
   output      xcfp_pkg::result_type result
);
   import xcfp_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           xor_ff, xor_in;
   logic [7:0]           id_ff, id_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic [7:0]           len_ff, len_in;
   logic                 mismatch_ff, mismatch_in;

   logic [7:0]           b;
   logic                 pos_is0, pos_is1, pos_is2, pos_is3;
   logic [7:0]           cur_id, cur_cmd, cur_len;
   logic                 cur_mismatch;
   logic [POS_WIDTH:0]   expected_pos;
   logic [POS_WIDTH:0]   payload_end;
   logic [POS_WIDTH-1:0] payload_offset;
   logic                 in_payload;
   logic [2:0]           code;

   assign b       = rx_byte.data_byte;
   assign pos_is0 = (pos_ff == POS_WIDTH'(0));
   assign pos_is1 = (pos_ff == POS_WIDTH'(1));
   assign pos_is2 = (pos_ff == POS_WIDTH'(2));
   assign pos_is3 = (pos_ff == POS_WIDTH'(3));

   // header fields including this byte
   assign cur_mismatch = pos_is0 ? (b != start_value) : mismatch_ff;
   assign cur_id       = pos_is1 ? b : id_ff;
   assign cur_cmd      = pos_is2 ? b : cmd_ff;
   assign cur_len      = pos_is3 ? b : len_ff;

   // the final byte sits at position header + length in a well-formed frame
   assign expected_pos   = (POS_WIDTH+1)'(HEADER_BYTES) + {{(POS_WIDTH-7){1'b0}}, cur_len};
   assign payload_end    = (POS_WIDTH+1)'(HEADER_BYTES) + {{(POS_WIDTH-7){1'b0}}, len_ff};
   assign payload_offset = pos_ff - POS_WIDTH'(HEADER_BYTES);
   assign in_payload     = (pos_ff >= POS_WIDTH'(HEADER_BYTES))
                        && ({1'b0, pos_ff} < payload_end);

   // verdict, first failing check wins
   always_comb begin
      if (pos_ff < POS_WIDTH'(HEADER_BYTES)) begin
         code = ERR_SHORT;
      end else if (cur_mismatch) begin
         code = ERR_START;
      end else if (cur_len > max_payload) begin
         code = ERR_LONG;
      end else if ({1'b0, pos_ff} != expected_pos) begin
         code = ERR_LENGTH;
      end else if (b != xor_ff) begin
         code = ERR_CHECK;
      end else begin
         code = ERR_OK;
      end
   end

   // result fields
   always_comb begin
      has_result            = rx_byte.last_byte || in_payload;
      result.is_verdict     = rx_byte.last_byte;
      result.payload_byte   = rx_byte.last_byte ? 8'd0 : b;
      result.payload_index  = rx_byte.last_byte ? 8'd0 : payload_offset[7:0];
      result.error_code     = rx_byte.last_byte ? code : ERR_OK;
      result.message_id     = cur_id;
      result.command        = cur_cmd;
      result.payload_length = cur_len;
   end

   // next frame state
   always_comb begin
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      id_in       = id_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      mismatch_in = mismatch_ff;
      if (step) begin
         if (rx_byte.last_byte) begin
            pos_in      = '0;
            xor_in      = '0;
            id_in       = '0;
            cmd_in      = '0;
            len_in      = '0;
            mismatch_in = 1'b0;
         end else begin
            xor_in      = xor_ff ^ b;
            pos_in      = (&pos_ff) ? pos_ff : pos_ff + POS_WIDTH'(1);
            id_in       = cur_id;
            cmd_in      = cur_cmd;
            len_in      = cur_len;
            mismatch_in = cur_mismatch;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         xor_ff      <= '0;
         id_ff       <= '0;
         cmd_ff      <= '0;
         len_ff      <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         xor_ff      <= xor_in;
         id_ff       <= id_in;
         cmd_ff      <= cmd_in;
         len_ff      <= len_in;
         mismatch_ff <= mismatch_in;
      end
   end

   // a verdict always starts a fresh frame
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      step && rx_byte.last_byte |=> (pos_ff == '0) && (xor_ff == '0) && !mismatch_ff)
      else $error("frame state not cleared after verdict");

   // payload results only inside the declared payload
   a_payload_index: assert property (@(posedge clock) disable iff (reset)
      has_result && !result.is_verdict |-> (result.payload_index < len_ff)
                                        && (result.error_code == ERR_OK))
      else $error("payload result outside declared length");

   // position only moves forward by one within a frame
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      step && !rx_byte.last_byte && !(&pos_ff) |=> pos_ff == $past(pos_ff) + POS_WIDTH'(1))
      else $error("byte position did not advance");

endmodule : xcfp_frame_check
`default_nettype wire

// ===== sv/xor_checked_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Byte-stream checker for length-prefixed frames with an XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a received buffer enter on the req_ channel (valid/ready), the
//   final byte marked by req_last_byte. Payload bytes come out on rsp_ as
//   they pass, and the final byte gives one verdict with the header fields.
//   Header bytes and bytes past the payload give no response.
//   Path: a request accepted on req_ passes the input register, the check
//   logic and the response register before it shows on rsp_.
//   Throughput: one request per cycle while rsp_ does not stall; the check
//   logic is a compare, an XOR and a counter update between the two registers.
//   Stall: while rsp_ready is low the response register holds, the input
//   register takes one more request, then req_ready drops.
//   Reset clears the frame state and the valid flags of both registers;
//   start_value returns to 170 and max_payload to 255. The csr_ port
//   writes a register and should only be used while no frame is in flight.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic                                  req_last_byte,
   // response channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic                                  rsp_is_verdict,
   output      logic [7:0]                            rsp_payload_byte,
   output      logic [7:0]                            rsp_payload_index,
   output      logic [2:0]                            rsp_error_code,
   output      logic [7:0]                            rsp_message_id,
   output      logic [7:0]                            rsp_command,
   output      logic [7:0]                            rsp_payload_length,
   // configuration
   input  wire logic                                  csr_write_enable,
   input  wire logic [xcfp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [7:0]                            csr_write_data
);
   import xcfp_pkg::*;

   logic [7:0]  start_value_ff;
   logic [7:0]  max_payload_ff;

   logic        in_valid_ff;
   rx_byte_type in_byte_ff;

   logic        out_valid_ff;
   result_type  out_ff;

   logic        advance;
   logic        has_result;
   result_type  result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= START_VALUE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_VALUE: start_value_ff <= csr_write_data;
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // the held request moves on once the response register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff.data_byte <= req_data_byte;
         in_byte_ff.last_byte <= req_last_byte;
      end
   end

   // frame state and checks
   xcfp_frame_check u_check (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .start_value (start_value_ff),
      .max_payload (max_payload_ff),
      .has_result  (has_result),
      .result      (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= has_result;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_is_verdict     = out_ff.is_verdict;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_index  = out_ff.payload_index;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_message_id     = out_ff.message_id;
   assign rsp_command        = out_ff.command;
   assign rsp_payload_length = out_ff.payload_length;

   // a stalled response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("response overwritten while stalled");

   // back-pressure only when a request is already held
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request refused without a stall");

   // a held request waits only on the response side
   a_held_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held request lost");

endmodule : xor_checked_frame_parser
`default_nettype wire
